// File: hw/rtl/occupancy_grid_ray_update_assert.svh
// Assertion shorthands for the grid updater; expect clk and rst_n in scope.
`ifndef OCCUPANCY_GRID_RAY_UPDATE_ASSERT_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define OGRU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define OGRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ogru_pkg.sv
package ogru_pkg;

    localparam int DEFAULT_GRID_WIDTH  = 256;
    localparam int DEFAULT_GRID_HEIGHT = 256;

    localparam int CELL_W     = 8;
    localparam int COUNT_W    = 11;
    localparam int COUNT_MAX  = 1024;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic signed [CELL_W-1:0] CELL_MAX = 8'sd127;
    localparam logic signed [CELL_W-1:0] CELL_MIN = -8'sd127;

    // operation codes
    localparam logic [1:0] OP_HIT  = 2'd0;
    localparam logic [1:0] OP_RAY  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_INCREMENT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_DECREMENT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] HIT_INCREMENT_RST  = 7'd3;
    localparam logic [CFG_DATA_W-1:0] MISS_DECREMENT_RST = 7'd1;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic               in_range;
    } in_beat_t;

    typedef struct packed {
        logic signed [CELL_W-1:0] cell_value;
        logic [COUNT_W-1:0]       cells_updated;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MODE_RAISE,
        MODE_LOWER,
        MODE_READ
    } mode_t;

    // v + inc, clamped at CELL_MAX
    function automatic logic signed [CELL_W-1:0] sat_raise(
        input logic signed [CELL_W-1:0] v,
        input logic [CFG_DATA_W-1:0]    inc
    );
        logic signed [9:0] head;
        logic signed [9:0] sum;
        head = 10'sd127 - $signed({{2{v[7]}}, v});
        sum  = $signed({{2{v[7]}}, v}) + $signed({3'b000, inc});
        if (head > $signed({3'b000, inc}))
            return sum[7:0];
        else
            return CELL_MAX;
    endfunction

    // v - dec, clamped at CELL_MIN
    function automatic logic signed [CELL_W-1:0] sat_lower(
        input logic signed [CELL_W-1:0] v,
        input logic [CFG_DATA_W-1:0]    dec
    );
        logic signed [9:0] room;
        logic signed [9:0] diff;
        room = $signed({{2{v[7]}}, v}) + 10'sd127;
        diff = $signed({{2{v[7]}}, v}) - $signed({3'b000, dec});
        if (room > $signed({3'b000, dec}))
            return diff[7:0];
        else
            return CELL_MIN;
    endfunction

endpackage

// File: hw/rtl/ogru_ram.sv
module ogru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/occupancy_grid_ray_update.sv
// Log-odds occupancy grid updater. The grid (GRID_WIDTH x GRID_HEIGHT signed
// 8-bit cells) lives in one single-port-write, registered-read RAM. After
// reset the block sweeps the RAM to zero, one cell per cycle; no input beat
// is taken during the sweep, register writes are taken at any time. A hit
// raises the end cell by hit_increment (clamped at +127) when in_range is
// set; a ray walks the Bresenham line from start to end, both ends included,
// lowering each in-grid cell by miss_decrement (clamped at -127); a read
// returns the start cell. Cells off the grid are skipped and report 0. One
// beat is worked at a time: the walker issues one RAM read per cycle for
// each in-grid cell it visits and the cell is written back the next cycle,
// the line holding one cell for a hit or a read and up to 65536 cells for
// the longest ray; a hit out of range or an unused operation code skips the
// walk. The walk is a read-modify-write of one cell per cycle through the
// grid RAM. A finished result waits in an output register, so the next beat
// is taken while the result is still pending; if the previous result is
// still unread when the next one finishes, the block holds in its done
// state until out_ready frees the register. cells_updated saturates at 1024.
module occupancy_grid_ray_update
    import ogru_pkg::*;
#(
    parameter int GRID_WIDTH  = DEFAULT_GRID_WIDTH,
    parameter int GRID_HEIGHT = DEFAULT_GRID_HEIGHT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_beat_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_beat_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "occupancy_grid_ray_update_assert.svh"

    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);

    // ---------------- configuration registers ----------------
    logic [CFG_DATA_W-1:0] hit_inc_reg;
    logic [CFG_DATA_W-1:0] miss_dec_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_inc_reg  <= HIT_INCREMENT_RST;
            miss_dec_reg <= MISS_DECREMENT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HIT_INCREMENT:  hit_inc_reg  <= cfg_data;
                CFG_MISS_DECREMENT: miss_dec_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // ---------------- state ----------------
    state_t state_reg, state_next;
    mode_t  mode_reg,  mode_next;

    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;

    // Bresenham walker: current cell, end cell, magnitudes, directions, error
    logic signed [15:0] x_reg,     x_next;
    logic signed [15:0] y_reg,     y_next;
    logic signed [15:0] x_end_reg, x_end_next;
    logic signed [15:0] y_end_reg, y_end_next;
    logic [15:0]        dx_reg,    dx_next;
    logic [15:0]        dy_reg,    dy_next;
    logic               x_neg_reg, x_neg_next;
    logic               y_neg_reg, y_neg_next;
    logic signed [18:0] err_reg,   err_next;

    // write-back stage: the cell whose read data arrives this cycle
    logic               pipe_valid_reg, pipe_valid_next;
    logic               pipe_last_reg,  pipe_last_next;
    logic [AW-1:0]      pipe_addr_reg,  pipe_addr_next;

    logic signed [CELL_W-1:0] value_reg, value_next;
    logic [COUNT_W-1:0]       cnt_reg,   cnt_next;

    logic      out_valid_reg, out_valid_next;
    out_beat_t out_data_reg,  out_data_next;

    // ---------------- RAM ----------------
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    ogru_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------- walker combinational ----------------
    logic               cell_in;
    logic [AW-1:0]      row_base;
    logic [AW-1:0]      cell_addr;
    logic               at_end;
    logic signed [19:0] e2;
    logic               step_x;
    logic               step_y;
    logic signed [18:0] err_stepped;

    assign cell_in = !x_reg[15] && ({1'b0, x_reg[14:0]} < 16'(GRID_WIDTH))
                  && !y_reg[15] && ({1'b0, y_reg[14:0]} < 16'(GRID_HEIGHT));
    assign row_base  = AW'(y_reg[YW-1:0]) * AW'(GRID_WIDTH);
    assign cell_addr = row_base + AW'(x_reg[XW-1:0]);
    assign at_end    = (x_reg == x_end_reg) && (y_reg == y_end_reg);

    assign e2     = {err_reg, 1'b0};
    assign step_x = e2 > -$signed({4'b0000, dy_reg});
    assign step_y = e2 < $signed({4'b0000, dx_reg});
    assign err_stepped = err_reg
                       - (step_x ? $signed({3'b000, dy_reg}) : 19'sd0)
                       + (step_y ? $signed({3'b000, dx_reg}) : 19'sd0);

    // setup of a new beat
    logic signed [16:0] diff_x;
    logic signed [16:0] diff_y;
    logic [15:0]        dx_abs;
    logic [15:0]        dy_abs;
    logic signed [16:0] diff_x_neg;
    logic signed [16:0] diff_y_neg;

    assign diff_x = $signed({in_data.end_x[15], in_data.end_x})
                  - $signed({in_data.start_x[15], in_data.start_x});
    assign diff_y = $signed({in_data.end_y[15], in_data.end_y})
                  - $signed({in_data.start_y[15], in_data.start_y});
    assign diff_x_neg = -diff_x;
    assign diff_y_neg = -diff_y;
    assign dx_abs = diff_x[16] ? diff_x_neg[15:0] : diff_x[15:0];
    assign dy_abs = diff_y[16] ? diff_y_neg[15:0] : diff_y[15:0];

    // write-back value of the cell in the pipe
    logic signed [CELL_W-1:0] cell_new;

    always_comb
    begin
        case (mode_reg)
            MODE_RAISE: cell_new = sat_raise(ram_rdata, hit_inc_reg);
            MODE_LOWER: cell_new = sat_lower(ram_rdata, miss_dec_reg);
            default:    cell_new = ram_rdata;
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        clr_cnt_next    = clr_cnt_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        x_end_next      = x_end_reg;
        y_end_next      = y_end_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        x_neg_next      = x_neg_reg;
        y_neg_next      = y_neg_reg;
        err_next        = err_reg;
        pipe_valid_next = 1'b0;
        pipe_last_next  = 1'b0;
        pipe_addr_next  = cell_addr;
        value_next      = value_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;

        ram_re    = 1'b0;
        ram_raddr = cell_addr;
        ram_we    = pipe_valid_reg && (mode_reg != MODE_READ);
        ram_waddr = pipe_addr_reg;
        ram_wdata = cell_new;

        // write-back of the previous cell
        if (pipe_valid_reg)
        begin
            if (mode_reg != MODE_READ && cnt_reg < COUNT_W'(COUNT_MAX))
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            if (pipe_last_reg)
            begin
                value_next = cell_new;
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    value_next = '0;
                    cnt_next   = '0;
                    dx_next    = dx_abs;
                    dy_next    = dy_abs;
                    x_neg_next = diff_x[16];
                    y_neg_next = diff_y[16];
                    err_next   = $signed({3'b000, dx_abs}) - $signed({3'b000, dy_abs});
                    x_next     = in_data.start_x;
                    y_next     = in_data.start_y;
                    x_end_next = in_data.end_x;
                    y_end_next = in_data.end_y;
                    state_next = ST_WALK;
                    case (in_data.operation)
                        OP_HIT:
                        begin
                            // single-cell walk on the end cell
                            mode_next = MODE_RAISE;
                            x_next    = in_data.end_x;
                            y_next    = in_data.end_y;
                            if (!in_data.in_range)
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        OP_RAY:
                        begin
                            mode_next = MODE_LOWER;
                        end
                        OP_READ:
                        begin
                            mode_next  = MODE_READ;
                            x_end_next = in_data.start_x;
                            y_end_next = in_data.start_y;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                ram_re          = cell_in;
                pipe_valid_next = cell_in;
                pipe_last_next  = at_end;
                if (at_end)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    err_next = err_stepped;
                    if (step_x)
                    begin
                        x_next = x_reg + (x_neg_reg ? 16'hFFFF : 16'h0001);
                    end
                    if (step_y)
                    begin
                        y_next = y_reg + (y_neg_reg ? 16'hFFFF : 16'h0001);
                    end
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.cell_value    = value_reg;
                    out_data_next.cells_updated = cnt_reg;
                    state_next                  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            mode_reg       <= MODE_READ;
            clr_cnt_reg    <= '0;
            pipe_valid_reg <= 1'b0;
            pipe_last_reg  <= 1'b0;
            value_reg      <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            clr_cnt_reg    <= clr_cnt_next;
            pipe_valid_reg <= pipe_valid_next;
            pipe_last_reg  <= pipe_last_next;
            value_reg      <= value_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        x_end_reg     <= x_end_next;
        y_end_reg     <= y_end_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        x_neg_reg     <= x_neg_next;
        y_neg_reg     <= y_neg_next;
        err_reg       <= err_next;
        pipe_addr_reg <= pipe_addr_next;
        out_data_reg  <= out_data_next;
    end

    // ---------------- assertions ----------------
    `OGRU_ASSERT_SAME(a_no_beat_in_clear, state_reg == ST_CLEAR, !in_ready,
        "input beat offered ready during clear sweep")
    `OGRU_ASSERT_SAME(a_rw_distinct, ram_we && ram_re, ram_waddr != ram_raddr,
        "grid read and write collide on one cell")
    `OGRU_ASSERT_SAME(a_count_cap, 1'b1, cnt_reg <= COUNT_W'(COUNT_MAX),
        "update count above cap")
    `OGRU_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, state_reg != ST_IDLE,
        "still idle after taking a beat")

endmodule
